/* rtl/core/mfb_pkg.sv */
// Shared constants for the max-flow engine: default sizes, field widths,
// configuration register indexes. No dependencies.
package mfb_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int CAP_BITS_DEF  = 16;

  localparam int NODE_W = 4;
  localparam int CAPP_W = 16;
  localparam int FLOW_W = 20;
  localparam int CFG_W  = 5;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SOURCE     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SINK       = 2'd2;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RST = 5'd16;
  localparam logic [NODE_W-1:0] SOURCE_RST     = 4'd0;
  localparam logic [NODE_W-1:0] SINK_RST       = 4'd15;

endpackage

/* rtl/core/mfb_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the capacity and residual stores. No dependencies.
module mfb_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1<<AW)-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mfb_ctrl.sv */
// Sequencer for the max-flow engine: store clear, copy, BFS, path walk,
// residual update and result register. Depends on mfb_pkg.
module mfb_ctrl #(
  parameter int MAX_NODES = mfb_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS  = mfb_pkg::CAP_BITS_DEF,
  parameter int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  parameter int AW = 2 * NW,
  parameter int RW = CAP_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [mfb_pkg::NODE_W-1:0]  in_from_node,
  input  logic [mfb_pkg::NODE_W-1:0]  in_to_node,
  input  logic [mfb_pkg::CAPP_W-1:0]  in_capacity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfb_pkg::FLOW_W-1:0]  out_total_flow,
  input  logic [mfb_pkg::CFG_W-1:0]   node_count,
  input  logic [mfb_pkg::NODE_W-1:0]  source_node,
  input  logic [mfb_pkg::NODE_W-1:0]  sink_node,
  output logic                        cap_we,
  output logic [AW-1:0]               cap_waddr,
  output logic [CAP_BITS-1:0]         cap_wdata,
  output logic [AW-1:0]               cap_raddr,
  input  logic [CAP_BITS-1:0]         cap_rdata,
  output logic                        res_we,
  output logic [AW-1:0]               res_waddr,
  output logic [RW-1:0]               res_wdata,
  output logic [AW-1:0]               res_raddr,
  input  logic [RW-1:0]               res_rdata
);

  localparam int NCW   = NW + 1;
  localparam int NE    = 1 << NW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [14:0] {
    ST_CLEAR    = 15'h0001,
    ST_IDLE     = 15'h0002,
    ST_COPY     = 15'h0004,
    ST_BFS_INIT = 15'h0008,
    ST_POP      = 15'h0010,
    ST_SCAN_RD  = 15'h0020,
    ST_SCAN_CK  = 15'h0040,
    ST_WALK_RD  = 15'h0080,
    ST_WALK_CK  = 15'h0100,
    ST_UPD_F_RD = 15'h0200,
    ST_UPD_F_WR = 15'h0400,
    ST_UPD_R_RD = 15'h0800,
    ST_UPD_R_WR = 15'h1000,
    ST_ADD      = 15'h2000,
    ST_DONE     = 15'h4000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW:0]                cnt_r, cnt_nxt;
  logic [NE-1:0]              visited_r, visited_nxt;
  logic [NW-1:0]              parent_r [NE-1:0];
  logic [NW-1:0]              parent_nxt [NE-1:0];
  logic [NW-1:0]              queue_r [NE-1:0];
  logic [NW-1:0]              queue_nxt [NE-1:0];
  logic [NCW-1:0]             head_r, head_nxt, tail_r, tail_nxt;
  logic [NCW-1:0]             v_r, v_nxt, steps_r, steps_nxt;
  logic [NW-1:0]              u_r, u_nxt, wv_r, wv_nxt;
  logic [RW-1:0]              neck_r, neck_nxt;
  logic [mfb_pkg::FLOW_W-1:0] flow_r, flow_nxt, out_flow_r, out_flow_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [NCW-1:0] n_w;
  logic [NW-1:0]  s_i, t_i, vi, par_w;
  logic           trivial, walk_go, accept;

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid & in_ready;
  assign out_valid      = out_valid_r;
  assign out_total_flow = out_flow_r;

  assign n_w = (32'(node_count) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count);
  assign s_i = NW'(source_node);
  assign t_i = NW'(sink_node);
  assign vi  = v_r[NW-1:0];
  assign par_w = parent_r[wv_r];
  assign walk_go = (wv_r != s_i) && (steps_r < n_w);
  assign trivial = (n_w < NCW'(2)) || (32'(source_node) >= 32'(n_w))
                || (32'(sink_node) >= 32'(n_w)) || (source_node == sink_node);

  always_comb begin
    cap_we    = 1'b0;
    cap_waddr = cnt_r[AW-1:0];
    cap_wdata = '0;
    cap_raddr = cnt_r[AW-1:0];
    res_we    = 1'b0;
    res_waddr = AW'(cnt_r - 1'b1);
    res_wdata = RW'(cap_rdata);
    res_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        cap_we = 1'b1;
      end
      ST_IDLE: begin
        cap_we    = accept && !in_req_type && (32'(in_from_node) < MAX_NODES)
                 && (32'(in_to_node) < MAX_NODES);
        cap_waddr = {NW'(in_from_node), NW'(in_to_node)};
        cap_wdata = CAP_BITS'(in_capacity);
      end
      ST_COPY: begin
        res_we = (cnt_r != '0);
      end
      ST_SCAN_RD: begin
        res_raddr = {u_r, vi};
      end
      ST_WALK_RD, ST_UPD_F_RD: begin
        res_raddr = {par_w, wv_r};
      end
      ST_UPD_R_RD: begin
        res_raddr = {wv_r, par_w};
      end
      ST_UPD_F_WR: begin
        res_we    = 1'b1;
        res_waddr = {par_w, wv_r};
        res_wdata = res_rdata - neck_r;
      end
      ST_UPD_R_WR: begin
        res_we    = 1'b1;
        res_waddr = {wv_r, par_w};
        res_wdata = res_rdata + neck_r;
      end
      default: begin
        res_raddr = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    visited_nxt   = visited_r;
    parent_nxt    = parent_r;
    queue_nxt     = queue_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    v_nxt         = v_r;
    steps_nxt     = steps_r;
    u_nxt         = u_r;
    wv_nxt        = wv_r;
    neck_nxt      = neck_r;
    flow_nxt      = flow_r;
    out_flow_nxt  = out_flow_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_req_type) begin
          flow_nxt = '0;
          cnt_nxt  = '0;
          state_nxt = trivial ? ST_DONE : ST_COPY;
        end
      end
      ST_COPY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(DEPTH)) begin
          state_nxt = ST_BFS_INIT;
        end
      end
      ST_BFS_INIT: begin
        visited_nxt      = '0;
        visited_nxt[s_i] = 1'b1;
        parent_nxt[s_i]  = s_i;
        queue_nxt[0]     = s_i;
        head_nxt         = '0;
        tail_nxt         = NCW'(1);
        state_nxt        = ST_POP;
      end
      ST_POP: begin
        if (head_r < tail_r) begin
          u_nxt     = queue_r[head_r[NW-1:0]];
          head_nxt  = head_r + 1'b1;
          v_nxt     = '0;
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = (v_r < n_w) ? ST_SCAN_CK : ST_POP;
      end
      ST_SCAN_CK: begin
        v_nxt     = v_r + 1'b1;
        state_nxt = ST_SCAN_RD;
        if (!visited_r[vi] && (res_rdata != '0)) begin
          parent_nxt[vi] = u_r;
          if (vi == t_i) begin
            neck_nxt  = '1;
            wv_nxt    = t_i;
            steps_nxt = '0;
            state_nxt = ST_WALK_RD;
          end else begin
            visited_nxt[vi] = 1'b1;
            if (tail_r < NCW'(MAX_NODES)) begin
              queue_nxt[tail_r[NW-1:0]] = vi;
              tail_nxt = tail_r + 1'b1;
            end
          end
        end
      end
      ST_WALK_RD: begin
        if (walk_go) begin
          state_nxt = ST_WALK_CK;
        end else begin
          wv_nxt    = t_i;
          steps_nxt = '0;
          state_nxt = ST_UPD_F_RD;
        end
      end
      ST_WALK_CK: begin
        if (res_rdata < neck_r) begin
          neck_nxt = res_rdata;
        end
        wv_nxt    = par_w;
        steps_nxt = steps_r + 1'b1;
        state_nxt = ST_WALK_RD;
      end
      ST_UPD_F_RD: begin
        state_nxt = walk_go ? ST_UPD_F_WR : ST_ADD;
      end
      ST_UPD_F_WR: begin
        state_nxt = ST_UPD_R_RD;
      end
      ST_UPD_R_RD: begin
        state_nxt = ST_UPD_R_WR;
      end
      ST_UPD_R_WR: begin
        wv_nxt    = par_w;
        steps_nxt = steps_r + 1'b1;
        state_nxt = ST_UPD_F_RD;
      end
      ST_ADD: begin
        flow_nxt  = flow_r + mfb_pkg::FLOW_W'(neck_r);
        state_nxt = ST_BFS_INIT;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flow_nxt  = flow_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      visited_r   <= '0;
      flow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      visited_r   <= visited_nxt;
      flow_r      <= flow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    parent_r   <= parent_nxt;
    queue_r    <= queue_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    v_r        <= v_nxt;
    steps_r    <= steps_nxt;
    u_r        <= u_nxt;
    wv_r       <= wv_nxt;
    neck_r     <= neck_nxt;
    out_flow_r <= out_flow_nxt;
  end

endmodule

/* rtl/core/max_flow_bfs_augment.sv */
// Max-flow engine top level: configuration registers, capacity and residual
// stores, sequencer. Depends on mfb_pkg, mfb_ram, mfb_ctrl.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   req_type, from_node, to_node, capacity
//   out_     output     out_valid/out_ready total_flow
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// After reset a clearing pass over the 4^ceil(log2 MAX_NODES) entries of the capacity
// store (256 at 16 nodes) runs with in_ready low. A run copies the capacity store
// into the residual store, then searches and augments; its pace is set by the single
// read port of the residual store. A waiting result does not block edge loads.
module max_flow_bfs_augment #(
  parameter int MAX_NODES = mfb_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS  = mfb_pkg::CAP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [mfb_pkg::NODE_W-1:0]  in_from_node,
  input  logic [mfb_pkg::NODE_W-1:0]  in_to_node,
  input  logic [mfb_pkg::CAPP_W-1:0]  in_capacity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfb_pkg::FLOW_W-1:0]  out_total_flow,
  input  logic                        cfg_we,
  input  logic [mfb_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mfb_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = 2 * NW;
  localparam int RW = CAP_BITS + 1;

  logic [mfb_pkg::CFG_W-1:0]  node_count_r;
  logic [mfb_pkg::NODE_W-1:0] source_r, sink_r;

  logic                cap_we, res_we;
  logic [AW-1:0]       cap_waddr, cap_raddr, res_waddr, res_raddr;
  logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
  logic [RW-1:0]       res_wdata, res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= mfb_pkg::NODE_COUNT_RST;
      source_r     <= mfb_pkg::SOURCE_RST;
      sink_r       <= mfb_pkg::SINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfb_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        mfb_pkg::CFG_SOURCE:     source_r <= cfg_wdata[mfb_pkg::NODE_W-1:0];
        mfb_pkg::CFG_SINK:       sink_r   <= cfg_wdata[mfb_pkg::NODE_W-1:0];
        default: begin
          node_count_r <= node_count_r;
        end
      endcase
    end
  end

  mfb_ram #(.AW(AW), .DW(CAP_BITS)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_waddr),
    .wdata (cap_wdata),
    .raddr (cap_raddr),
    .rdata (cap_rdata)
  );

  mfb_ram #(.AW(AW), .DW(RW)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  mfb_ctrl #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS), .NW(NW), .AW(AW), .RW(RW)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_capacity    (in_capacity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_total_flow (out_total_flow),
    .node_count     (node_count_r),
    .source_node    (source_r),
    .sink_node      (sink_r),
    .cap_we         (cap_we),
    .cap_waddr      (cap_waddr),
    .cap_wdata      (cap_wdata),
    .cap_raddr      (cap_raddr),
    .cap_rdata      (cap_rdata),
    .res_we         (res_we),
    .res_waddr      (res_waddr),
    .res_wdata      (res_wdata),
    .res_raddr      (res_raddr),
    .res_rdata      (res_rdata)
  );

endmodule
